FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the stepper ramp RTL.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge out of reset.
`define SRRG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SRRG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/srrg_pkg.sv
// Package for the stepper rate ramp generator: beat types, register
// indexes, sequencer states and serial unit widths. No dependencies.
`timescale 1ns / 1ps

package srrg_pkg;

    localparam int DIV_NUM_W  = 48;
    localparam int DIV_DEN_W  = 64;
    localparam int MUL_W      = 32;
    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = 32;
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam logic [2:0] REG_STEP_RATE   = 3'd0;
    localparam logic [2:0] REG_ACCEL_OFS   = 3'd1;
    localparam logic [2:0] REG_ACCEL_SCALE = 3'd2;
    localparam logic [2:0] REG_STOP_THR    = 3'd3;
    localparam logic [2:0] REG_MIN_SPEED   = 3'd4;
    localparam logic [2:0] REG_STEP_DEG    = 3'd5;

    localparam logic REQ_SET_SPEED = 1'b0;
    localparam logic REQ_COMPARE   = 1'b1;

    localparam logic [15:0] HALF_MAX = 16'hFFFF;

    typedef struct packed {
        logic               req_type;
        logic signed [23:0] target_speed;
    } srrg_in_t;

    typedef struct packed {
        logic               step_level;
        logic               direction;
        logic               running;
        logic [15:0]        half_period;
        logic               kick;
        logic signed [31:0] position;
    } srrg_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SDIV,
        ST_DECIDE,
        ST_SQMUL,
        ST_ROOT,
        ST_CQMUL,
        ST_LIMDIV,
        ST_CLAMP,
        ST_HPDIV,
        ST_FINISH
    } seq_state_t;

endpackage

FILE: hw/rtl/srrg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on srrg_pkg for widths and the status struct.
`timescale 1ns / 1ps

module srrg_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [srrg_pkg::DIV_NUM_W-1:0]    num,
    input  logic [srrg_pkg::DIV_DEN_W-1:0]    den,
    output logic [srrg_pkg::DIV_NUM_W-1:0]    quo,
    output srrg_pkg::unit_stat_t              stat
);
    import srrg_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(DIV_NUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = diff[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: hw/rtl/srrg_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on srrg_pkg for widths and the status struct.
`timescale 1ns / 1ps

module srrg_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [srrg_pkg::MUL_W-1:0]      a,
    input  logic [srrg_pkg::MUL_W-1:0]      b,
    output logic [2*srrg_pkg::MUL_W-1:0]    prod,
    output srrg_pkg::unit_stat_t            stat
);
    import srrg_pkg::*;

    localparam int CNT_W = $clog2(MUL_W);

    logic [2*MUL_W-1:0] a_reg, a_next;
    logic [MUL_W-1:0]   b_reg, b_next;
    logic [2*MUL_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = {{MUL_W{1'b0}}, a};
            b_next    = b;
            acc_next  = '0;
            cnt_next  = CNT_W'(MUL_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next = {a_reg[2*MUL_W-2:0], 1'b0};
            b_next = {1'b0, b_reg[MUL_W-1:1]};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign prod      = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: hw/rtl/srrg_sqrt.sv
// Digit-serial integer square root, one root bit (two radicand bits) per cycle.
// Depends on srrg_pkg for widths and the status struct.
`timescale 1ns / 1ps

module srrg_sqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [srrg_pkg::SQRT_IN_W-1:0]    radicand,
    output logic [srrg_pkg::SQRT_OUT_W-1:0]   root,
    output srrg_pkg::unit_stat_t              stat
);
    import srrg_pkg::*;

    localparam int CNT_W = $clog2(SQRT_OUT_W);
    localparam int REM_W = SQRT_OUT_W + 2;

    logic [SQRT_IN_W-1:0]  v_reg, v_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [SQRT_OUT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [REM_W+1:0]      rem_sh;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      diff;

    always_comb
    begin
        rem_sh    = {rem_reg, v_reg[SQRT_IN_W-1:SQRT_IN_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        diff      = rem_sh - trial;
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(SQRT_OUT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_reg[SQRT_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[SQRT_OUT_W-2:0], 1'b0};
            end
            v_next = {v_reg[SQRT_IN_W-3:0], 2'b00};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: hw/rtl/stepper_rate_ramp_generator_core.sv
// Stepper rate ramp generator top level: APB registers, sequencer, step state.
// Depends on srrg_pkg, srrg_div, srrg_mul, srrg_sqrt and assert_macros.svh.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+-----------------------
//   in       | in  | in_valid / in_stall   | srrg_in_t  in_data
//   out      | out | out_valid / out_stall | srrg_out_t out_data
//   cfg      | in  | APB, pready tied high | 64-bit regs at 8*index
//
// A compare beat goes from idle straight to the finish state. A set-speed
// beat runs up to three serial divides, two serial multiplies and a serial
// root, one after another. One beat is in work at a time; the next is
// accepted once the result is registered, even while out_stall holds it.
// Reset is asynchronous, active low, with no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stepper_rate_ramp_generator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  srrg_pkg::srrg_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output srrg_pkg::srrg_out_t               out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srrg_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [srrg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [srrg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import srrg_pkg::*;

    // configuration
    logic [31:0] step_rate_reg, step_rate_next;
    logic [47:0] accel_ofs_reg, accel_ofs_next;
    logic [31:0] accel_scale_reg, accel_scale_next;
    logic [15:0] stop_thr_reg, stop_thr_next;
    logic [15:0] min_speed_reg, min_speed_next;
    logic [23:0] step_deg_reg, step_deg_next;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    // motor state
    logic        toggle_phase_reg, toggle_phase_next;
    logic        pin_level_reg, pin_level_next;
    logic        turn_ccw_reg, turn_ccw_next;
    logic        is_stopped_reg, is_stopped_next;
    logic        int_enable_reg, int_enable_next;
    logic [15:0] active_hp_reg, active_hp_next;
    logic [15:0] pending_hp_reg, pending_hp_next;
    logic [31:0] angle_acc_reg, angle_acc_next;

    // work registers for the beat in flight
    seq_state_t  state_reg, state_next;
    logic        req_reg, req_next;
    logic [23:0] raw_reg, raw_next;
    logic [31:0] s_reg, s_next;
    logic [23:0] mag_reg, mag_next;
    logic        ccw_new_reg, ccw_new_next;
    logic        stop_reg, stop_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    srrg_out_t   out_data_reg, out_data_next;

    // serial units
    logic                    div_start, mul_start, sqrt_start;
    logic [DIV_NUM_W-1:0]    div_num, div_quo;
    logic [DIV_DEN_W-1:0]    div_den;
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [2*MUL_W-1:0]      mul_prod;
    logic [SQRT_IN_W-1:0]    sqrt_in;
    logic [SQRT_OUT_W-1:0]   sqrt_root;
    unit_stat_t              div_stat, mul_stat, sqrt_stat;

    // decision terms
    logic        in_acc;
    logic        slot_free;
    logic        dec_neg;
    logic [23:0] dec_mag;
    logic        dec_stop;
    logic        dec_ramp;
    logic [64:0] sq_sum;
    logic [23:0] clamp_mag;
    logic [46:0] hp_q;
    logic [15:0] hp_sat;
    logic        commit;

    srrg_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .quo    (div_quo),
        .stat   (div_stat)
    );

    srrg_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .prod   (mul_prod),
        .stat   (mul_stat)
    );

    srrg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .root     (sqrt_root),
        .stat     (sqrt_stat)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == ST_FINISH) && slot_free;
    assign pready    = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- configuration port ----------------
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    always_comb
    begin
        step_rate_next   = step_rate_reg;
        accel_ofs_next   = accel_ofs_reg;
        accel_scale_next = accel_scale_reg;
        stop_thr_next    = stop_thr_reg;
        min_speed_next   = min_speed_reg;
        step_deg_next    = step_deg_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_STEP_RATE:   step_rate_next   = pwdata[31:0];
                REG_ACCEL_OFS:   accel_ofs_next   = pwdata[47:0];
                REG_ACCEL_SCALE: accel_scale_next = pwdata[31:0];
                REG_STOP_THR:    stop_thr_next    = pwdata[15:0];
                REG_MIN_SPEED:   min_speed_next   = pwdata[15:0];
                REG_STEP_DEG:    step_deg_next    = pwdata[23:0];
                default:         step_rate_next   = step_rate_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_STEP_RATE:   prdata = {32'b0, step_rate_reg};
            REG_ACCEL_OFS:   prdata = {16'b0, accel_ofs_reg};
            REG_ACCEL_SCALE: prdata = {32'b0, accel_scale_reg};
            REG_STOP_THR:    prdata = {48'b0, stop_thr_reg};
            REG_MIN_SPEED:   prdata = {48'b0, min_speed_reg};
            REG_STEP_DEG:    prdata = {40'b0, step_deg_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------- decision terms ----------------
    always_comb
    begin
        dec_neg = raw_reg[23];
        dec_mag = dec_neg ? (24'h800000 - {1'b0, raw_reg[22:0]}) : {1'b0, raw_reg[22:0]};
        if (dec_mag == '0)
        begin
            dec_neg = 1'b0;
        end
        // while the speed is nonzero, a target against the present direction of turn becomes zero
        if ((s_reg != '0) &&
            ((turn_ccw_reg && dec_neg) || (!turn_ccw_reg && !dec_neg && (dec_mag != '0))))
        begin
            dec_mag = '0;
            dec_neg = 1'b0;
        end
        dec_stop  = (dec_mag < {8'b0, stop_thr_reg});
        dec_ramp  = ({8'b0, dec_mag} > s_reg);
        sq_sum    = {1'b0, mul_prod} + {17'b0, accel_ofs_reg};
        clamp_mag = (mag_reg < {8'b0, min_speed_reg}) ? {8'b0, min_speed_reg} : mag_reg;
        hp_q      = div_quo[DIV_NUM_W-1:1];
        hp_sat    = (hp_q[46:16] != '0) ? HALF_MAX : hp_q[15:0];
    end

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_data.req_type == REQ_COMPARE)
                        state_next = ST_FINISH;
                    else if (is_stopped_reg || (active_hp_reg == '0))
                        state_next = ST_DECIDE;
                    else
                        state_next = ST_SDIV;
                end
            end
            ST_SDIV:
            begin
                if (div_stat.done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (dec_stop)
                    state_next = ST_FINISH;
                else if (dec_ramp)
                    state_next = ST_SQMUL;
                else
                    state_next = ST_CLAMP;
            end
            ST_SQMUL:
            begin
                if (mul_stat.done)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sqrt_stat.done)
                    state_next = ST_CQMUL;
            end
            ST_CQMUL:
            begin
                if (mul_stat.done)
                    state_next = (mul_prod == '0) ? ST_CLAMP : ST_LIMDIV;
            end
            ST_LIMDIV:
            begin
                if (div_stat.done)
                    state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                state_next = (clamp_mag == '0) ? ST_FINISH : ST_HPDIV;
            end
            ST_HPDIV:
            begin
                if (div_stat.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- sequencer: unit launches ----------------
    always_comb
    begin
        div_start  = 1'b0;
        div_num    = {16'b0, step_rate_reg};
        div_den    = {48'b0, active_hp_reg};
        mul_start  = 1'b0;
        mul_a      = s_reg;
        mul_b      = s_reg;
        sqrt_start = 1'b0;
        sqrt_in    = sq_sum[64] ? {SQRT_IN_W{1'b1}} : sq_sum[63:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                div_start = in_acc && (in_data.req_type == REQ_SET_SPEED) &&
                            !is_stopped_reg && (active_hp_reg != '0);
            end
            ST_DECIDE:
            begin
                mul_start = !dec_stop && dec_ramp;
            end
            ST_SQMUL:
            begin
                sqrt_start = mul_stat.done;
            end
            ST_ROOT:
            begin
                mul_start = sqrt_stat.done;
                mul_a     = sqrt_root - s_reg;
                mul_b     = accel_scale_reg;
            end
            ST_CQMUL:
            begin
                div_start = mul_stat.done && (mul_prod != '0);
                div_num   = {step_rate_reg, 16'b0};
                div_den   = mul_prod;
            end
            ST_CLAMP:
            begin
                div_start = (clamp_mag != '0);
                div_den   = {40'b0, clamp_mag};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // ---------------- datapath and step state ----------------
    always_comb
    begin
        req_next          = req_reg;
        raw_next          = raw_reg;
        s_next            = s_reg;
        mag_next          = mag_reg;
        ccw_new_next      = ccw_new_reg;
        stop_next         = stop_reg;
        toggle_phase_next = toggle_phase_reg;
        pin_level_next    = pin_level_reg;
        turn_ccw_next     = turn_ccw_reg;
        is_stopped_next   = is_stopped_reg;
        int_enable_next   = int_enable_reg;
        active_hp_next    = active_hp_reg;
        pending_hp_next   = pending_hp_reg;
        angle_acc_next    = angle_acc_reg;
        out_data_next     = out_data_reg;
        out_valid_next    = out_stall ? out_valid_reg : 1'b0;

        if (in_acc)
        begin
            req_next = in_data.req_type;
            raw_next = in_data.target_speed;
            if (is_stopped_reg)
                s_next = '0;
            else if (active_hp_reg == '0)
                s_next = '1;
        end

        if ((state_reg == ST_SDIV) && div_stat.done)
            s_next = div_quo[31:0];

        if (state_reg == ST_DECIDE)
        begin
            mag_next     = dec_mag;
            ccw_new_next = !dec_neg;
            stop_next    = dec_stop;
        end

        // take the ramp limit when it is below the target
        if ((state_reg == ST_LIMDIV) && div_stat.done && (div_quo < {24'b0, mag_reg}))
            mag_next = div_quo[23:0];

        if ((state_reg == ST_CLAMP) && (clamp_mag == '0))
            pending_hp_next = HALF_MAX;

        if ((state_reg == ST_HPDIV) && div_stat.done)
            pending_hp_next = hp_sat;

        if (commit)
        begin
            out_data_next.kick = 1'b0;
            if (req_reg == REQ_COMPARE)
            begin
                if (int_enable_reg)
                begin
                    if (toggle_phase_reg)
                    begin
                        pin_level_next    = 1'b0;
                        toggle_phase_next = 1'b0;
                    end
                    else
                    begin
                        pin_level_next    = 1'b1;
                        toggle_phase_next = 1'b1;
                        if (turn_ccw_reg)
                            angle_acc_next = angle_acc_reg + {8'b0, step_deg_reg};
                        else
                            angle_acc_next = angle_acc_reg - {8'b0, step_deg_reg};
                    end
                    active_hp_next  = pending_hp_reg;
                    is_stopped_next = 1'b0;
                end
            end
            else
            begin
                turn_ccw_next = ccw_new_reg;
                if (stop_reg)
                begin
                    if (!is_stopped_reg)
                    begin
                        int_enable_next = 1'b0;
                        pin_level_next  = 1'b0;
                        is_stopped_next = 1'b1;
                    end
                end
                else if (is_stopped_reg)
                begin
                    int_enable_next    = 1'b1;
                    out_data_next.kick = 1'b1;
                end
            end
            out_data_next.step_level  = pin_level_next;
            out_data_next.direction   = turn_ccw_next;
            out_data_next.running     = int_enable_next;
            out_data_next.half_period = active_hp_next;
            out_data_next.position    = angle_acc_next;
            out_valid_next            = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            step_rate_reg    <= '0;
            accel_ofs_reg    <= '0;
            accel_scale_reg  <= '0;
            stop_thr_reg     <= 16'd1;
            min_speed_reg    <= 16'd1;
            step_deg_reg     <= '0;
            toggle_phase_reg <= 1'b0;
            pin_level_reg    <= 1'b0;
            turn_ccw_reg     <= 1'b1;
            is_stopped_reg   <= 1'b1;
            int_enable_reg   <= 1'b0;
            active_hp_reg    <= '0;
            pending_hp_reg   <= '0;
            angle_acc_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            step_rate_reg    <= step_rate_next;
            accel_ofs_reg    <= accel_ofs_next;
            accel_scale_reg  <= accel_scale_next;
            stop_thr_reg     <= stop_thr_next;
            min_speed_reg    <= min_speed_next;
            step_deg_reg     <= step_deg_next;
            toggle_phase_reg <= toggle_phase_next;
            pin_level_reg    <= pin_level_next;
            turn_ccw_reg     <= turn_ccw_next;
            is_stopped_reg   <= is_stopped_next;
            int_enable_reg   <= int_enable_next;
            active_hp_reg    <= active_hp_next;
            pending_hp_reg   <= pending_hp_next;
            angle_acc_reg    <= angle_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        raw_reg      <= raw_next;
        s_reg        <= s_next;
        mag_reg      <= mag_next;
        ccw_new_reg  <= ccw_new_next;
        stop_reg     <= stop_next;
        out_data_reg <= out_data_next;
    end

    // ---------------- assertions ----------------
    `SRRG_ASSERT_IMP(a_kick_runs, out_valid_reg && out_data_reg.kick, out_data_reg.running, "kick without running")
    `SRRG_ASSERT_IMP(a_stop_pin_low, is_stopped_reg, !pin_level_reg, "step pin high while stopped")
    `SRRG_ASSERT_IMP(a_div_done_waited, div_stat.done, (state_reg == ST_SDIV) || (state_reg == ST_LIMDIV) || (state_reg == ST_HPDIV), "divider result with no waiting state")
    `SRRG_ASSERT(a_no_restart, !((div_start && div_stat.busy) || (mul_start && mul_stat.busy) || (sqrt_start && sqrt_stat.busy)), "serial unit restarted while busy")

endmodule
